// File: rtl/lsf_pkg.sv
// Shared types and constants of the line substring filter.
// Used by lsf_front, lsf_back and line_substring_filter_top; depends on nothing.
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 7;
  localparam int unsigned PLEN_W    = 7;
  localparam int unsigned OUT_LEN_W = 8;

  localparam logic [BYTE_W-1:0] CHAR_NL  = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_LOAD = 2'd2
  } lsf_kind_e;

  // One classified request as it sits in the queue.
  typedef struct packed {
    lsf_kind_e          kind;
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
  } lsf_item_t;

  // Control from the back part to the front part.
  typedef struct packed {
    logic pop;
    logic busy;
  } lsf_ctl_t;

endpackage

// File: rtl/line_substring_filter_top.sv
// Top level of the line substring filter: port packing and the front/back split.
// Depends on lsf_pkg, lsf_front, lsf_back (and lsf_ram below it).
//
// Channel | Direction | Handshake                      | Payload
// --------+-----------+--------------------------------+---------------------------------------
// s_axis  | in        | s_axis_tvalid / s_axis_tready  | tuser: command; tdata: byte, index
// m_axis  | out       | m_axis_tvalid / m_axis_tready  | tdata: line_matched, line_length
// cfg     | in        | cfg_valid_i / cfg_ready_o      | cfg_data_i: pattern_length
//
// Sustained rate is one request per cycle; the text window compare over all PATTERN_MAX
// lanes settles in the cycle a byte leaves the queue. A line end waits only when the
// result register is still full; requests behind it wait in the two-entry queue, and the
// input stalls once that queue is full.
// A pattern_length write starts a rebuild that copies the pattern store into lane order
// through its one read port; requests and further writes are held off meanwhile. Reset
// needs no clearing pass.
`timescale 1ns / 1ps

module line_substring_filter_top #(
  parameter int unsigned PATTERN_MAX = 127,
  parameter int unsigned LINE_MAX    = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [14:8] pattern_index, [15] zero
  input  logic [0:0]  s_axis_tuser,  // [0] command

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] line_matched, [8:1] line_length, [15:9] zero

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i      // pattern_length
);

  lsf_pkg::lsf_ctl_t  ctl;
  lsf_pkg::lsf_item_t item;
  logic               item_valid;
  logic               out_matched;
  logic [lsf_pkg::OUT_LEN_W-1:0] out_length;

  // Front: classify each request and park it in the queue; drop loads past the store.
  lsf_front #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata[7:0]),
    .in_index_i  (s_axis_tdata[14:8]),
    .ctl_i       (ctl),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  // Back: advance the window, track the line, hold one result for the output side.
  lsf_back #(
    .PATTERN_MAX(PATTERN_MAX),
    .LINE_MAX   (LINE_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .ctl_o        (ctl),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_matched_o(out_matched),
    .out_length_o (out_length)
  );

  assign m_axis_tdata = {7'b0, out_length, out_matched};

endmodule

// File: rtl/lsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 127
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lsf_front.sv
// Front part: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_front #(
  parameter int unsigned PATTERN_MAX = 127
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  input  logic [lsf_pkg::BYTE_W-1:0]  in_data_i,
  input  logic [lsf_pkg::INDEX_W-1:0] in_index_i,
  input  lsf_pkg::lsf_ctl_t           ctl_i,
  output logic                        item_valid_o,
  output lsf_pkg::lsf_item_t          item_o
);

  localparam int unsigned CW = (lsf_pkg::INDEX_W > 8) ? lsf_pkg::INDEX_W : 8;

  lsf_pkg::lsf_item_t cls_item;
  logic               cls_keep;
  logic               push;

  lsf_pkg::lsf_item_t ent_q [2];
  logic [1:0]         fill_q, fill_d;
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;

  // Classify: drop loads beyond the store, split text into bytes and line ends.
  always_comb begin
    cls_item.data  = in_data_i;
    cls_item.index = in_index_i;
    cls_keep       = 1'b1;
    if (in_cmd_i == lsf_pkg::CMD_LOAD) begin
      cls_item.kind = lsf_pkg::KIND_LOAD;
      cls_keep      = CW'(in_index_i) < CW'(PATTERN_MAX);
    end else if (in_data_i == lsf_pkg::CHAR_NL || in_data_i == lsf_pkg::CHAR_NUL) begin
      cls_item.kind = lsf_pkg::KIND_EOL;
    end else begin
      cls_item.kind = lsf_pkg::KIND_TEXT;
    end
  end

  assign in_ready_o = (fill_q != 2'd2) && !ctl_i.busy;
  assign push       = in_valid_i && in_ready_o && cls_keep;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = ctl_i.pop ? ~rd_ptr_q : rd_ptr_q;
    case ({push, ctl_i.pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls_item;
    end
  end

  assign item_valid_o = fill_q != 2'd0;
  assign item_o       = ent_q[rd_ptr_q];

endmodule

// File: rtl/lsf_back.sv
// Back part: pattern store, aligned pattern copy, text window, line state and result register.
// Depends on lsf_pkg and lsf_ram.
`timescale 1ns / 1ps

module lsf_back #(
  parameter int unsigned PATTERN_MAX = 127,
  parameter int unsigned LINE_MAX    = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  lsf_pkg::lsf_item_t            item_i,
  output lsf_pkg::lsf_ctl_t             ctl_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsf_pkg::PLEN_W-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_matched_o,
  output logic [lsf_pkg::OUT_LEN_W-1:0] out_length_o
);

  localparam int unsigned PLW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned KW  = $clog2(LINE_MAX + 1);
  localparam int unsigned AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned EW  = (PLW > lsf_pkg::PLEN_W) ? PLW : lsf_pkg::PLEN_W;
  localparam int unsigned CW  = (KW > PLW) ? KW : PLW;

  logic [lsf_pkg::PLEN_W-1:0] plen_q, plen_d;
  logic [PLW-1:0]             plen_eff;
  logic                       busy_q, busy_d;
  logic [PLW-1:0]             sweep_cnt_q, sweep_cnt_d;
  logic                       rd_valid_q, rd_valid_d;
  logic [PLW-1:0]             rd_lane_q, rd_lane_d;
  logic                       rd_issue;
  logic [AW-1:0]              rd_addr;
  logic [lsf_pkg::BYTE_W-1:0] rd_data;

  logic [KW-1:0]              kept_q, kept_d, kept_next;
  logic                       found_q, found_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_matched_q;
  logic [lsf_pkg::OUT_LEN_W-1:0] out_len_q;

  logic [lsf_pkg::BYTE_W-1:0] win_q  [PATTERN_MAX];
  logic [lsf_pkg::BYTE_W-1:0] apat_q [PATTERN_MAX];
  logic [lsf_pkg::BYTE_W-1:0] win_next [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     lane_ok;

  logic cfg_fire, out_free, pop, is_text, is_eol, is_load;
  logic text_keep, load_hit, window_hit, line_hit;
  logic [EW-1:0] load_lane;

  assign plen_eff = (EW'(plen_q) > EW'(PATTERN_MAX)) ? PLW'(PATTERN_MAX) : PLW'(plen_q);

  assign cfg_ready_o = !busy_q;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_text  = item_i.kind == lsf_pkg::KIND_TEXT;
  assign is_eol   = item_i.kind == lsf_pkg::KIND_EOL;
  assign is_load  = item_i.kind == lsf_pkg::KIND_LOAD;
  assign pop      = item_valid_i && !busy_q && (!is_eol || out_free);

  assign ctl_o.pop  = pop;
  assign ctl_o.busy = busy_q;

  assign text_keep = pop && is_text && (kept_q != KW'(LINE_MAX));
  assign kept_next = kept_q + KW'(1);
  assign load_hit  = pop && is_load && (EW'(item_i.index) < EW'(plen_eff));
  assign load_lane = EW'(plen_eff) - EW'(1) - EW'(item_i.index);

  // Rebuild sweep: copy the store into lane order, one entry per cycle.
  assign rd_issue = busy_q && (sweep_cnt_q != plen_eff);
  assign rd_addr  = AW'(plen_eff - PLW'(1) - sweep_cnt_q);

  lsf_ram #(
    .WIDTH(lsf_pkg::BYTE_W),
    .DEPTH(PATTERN_MAX)
  ) u_pat_ram (
    .clk_i  (clk_i),
    .we_i   (pop && is_load),
    .waddr_i(AW'(item_i.index)),
    .wdata_i(item_i.data),
    .re_i   (rd_issue),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Window compare: lane k holds the k-th newest byte against its aligned pattern byte.
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      win_next[k] = (k == 0) ? item_i.data : win_q[(k == 0) ? 0 : k - 1];
      lane_ok[k]  = (EW'(k) >= EW'(plen_eff)) || (win_next[k] == apat_q[k]);
    end
  end

  assign window_hit = (plen_eff != '0) && (CW'(kept_next) >= CW'(plen_eff)) && (&lane_ok);
  assign line_hit   = found_q || ((plen_eff == '0) && (kept_q != '0));

  always_comb begin
    plen_d      = plen_q;
    busy_d      = busy_q;
    sweep_cnt_d = sweep_cnt_q;
    rd_valid_d  = rd_issue;
    rd_lane_d   = sweep_cnt_q;
    kept_d      = kept_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_fire) begin
      plen_d      = cfg_data_i;
      busy_d      = 1'b1;
      sweep_cnt_d = '0;
    end else if (busy_q) begin
      if (rd_issue) begin
        sweep_cnt_d = sweep_cnt_q + PLW'(1);
      end else if (!rd_valid_q) begin
        busy_d = 1'b0;
      end
    end

    if (text_keep) begin
      kept_d = kept_next;
      if (window_hit) begin
        found_d = 1'b1;
      end
    end
    if (pop && is_eol) begin
      out_valid_d = 1'b1;
      kept_d      = '0;
      found_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      busy_q      <= 1'b0;
      sweep_cnt_q <= '0;
      rd_valid_q  <= 1'b0;
      kept_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      plen_q      <= plen_d;
      busy_q      <= busy_d;
      sweep_cnt_q <= sweep_cnt_d;
      rd_valid_q  <= rd_valid_d;
      kept_q      <= kept_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lane_q <= rd_lane_d;
    if (pop && is_eol) begin
      out_matched_q <= line_hit;
      out_len_q     <= lsf_pkg::OUT_LEN_W'(kept_q);
    end
    if (text_keep) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_q[k] <= win_next[k];
      end
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (rd_valid_q && (rd_lane_q == PLW'(k))) begin
        apat_q[k] <= rd_data;
      end else if (load_hit && (load_lane == EW'(k))) begin
        apat_q[k] <= item_i.data;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_matched_o = out_matched_q;
  assign out_length_o  = out_len_q;

  a_no_pop_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pop) else $error("request taken during pattern rebuild");

  a_kept_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KW'(LINE_MAX)) else $error("kept count beyond line limit");

  a_found_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (kept_q != '0)) else $error("match flag set on empty line");

  a_eol_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && is_eol) |=> out_valid_q) else $error("line end gave no result");

  a_read_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> busy_q) else $error("store read outside rebuild");

endmodule

// File: verif/line_verdict_checker.sv
// line_verdict_checker: watches the request, result and length-write channels of the
// line substring filter, predicts one verdict per finished line and compares in order.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module line_verdict_checker #(
  parameter int unsigned PATTERN_MAX = 127,
  parameter int unsigned LINE_MAX    = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          due_count_o
);

  typedef struct packed {
    logic                          matched;
    logic [lsf_pkg::OUT_LEN_W-1:0] length;
  } line_verdict_t;

  logic [lsf_pkg::BYTE_W-1:0] pattern_bytes [PATTERN_MAX];  // left X until loaded
  logic [lsf_pkg::BYTE_W-1:0] recent_bytes  [PATTERN_MAX];  // [0] is the newest kept byte
  int unsigned                kept_bytes = 0;
  logic                       found = 1'b0;
  logic [lsf_pkg::PLEN_W-1:0] used_length = '0;
  line_verdict_t              verdicts_due [$];
  int                         fail_count = 0;
  int                         due_count = 0;

  assign fail_count_o = fail_count;
  assign due_count_o  = due_count;

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: line verdict error: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    line_verdict_t               got;
    line_verdict_t               want;
    logic [lsf_pkg::BYTE_W-1:0]  value;
    logic [lsf_pkg::INDEX_W-1:0] idx;
    int unsigned                 plen;
    logic                        hit;
    if (!rst_ni) begin
      verdicts_due.delete();
      for (int k = 0; k < PATTERN_MAX; k++) recent_bytes[k] = '0;
      kept_bytes  = 0;
      found       = 1'b0;
      used_length = '0;
      due_count   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) used_length = cfg_data_i;
      plen = (used_length > PATTERN_MAX) ? PATTERN_MAX : used_length;

      // Compare the result first: it can only belong to a line finished earlier.
      if (m_axis_tvalid && m_axis_tready) begin
        got.matched = m_axis_tdata[0];
        got.length  = m_axis_tdata[8:1];
        if (verdicts_due.size() == 0) begin
          report_failure($sformatf("unexpected result matched=%0b length=%0d",
                                   got.matched, got.length));
        end else begin
          want = verdicts_due.pop_front();
          if (got.matched !== want.matched || got.length !== want.length)
            report_failure($sformatf("expected matched=%0b length=%0d, got matched=%0b length=%0d",
                                     want.matched, want.length, got.matched, got.length));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        value = s_axis_tdata[7:0];
        idx   = s_axis_tdata[14:8];
        if (s_axis_tuser[0] == lsf_pkg::CMD_LOAD) begin
          if (idx < PATTERN_MAX) pattern_bytes[idx] = value;
        end else if (value == lsf_pkg::CHAR_NL || value == lsf_pkg::CHAR_NUL) begin
          // An empty pattern hits any line that kept at least one byte.
          want.matched = found || (plen == 0 && kept_bytes > 0);
          want.length  = lsf_pkg::OUT_LEN_W'(kept_bytes);
          verdicts_due.push_back(want);
          kept_bytes = 0;
          found      = 1'b0;
        end else if (kept_bytes < LINE_MAX) begin
          for (int k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
          recent_bytes[0] = value;
          kept_bytes++;
          if (plen != 0 && kept_bytes >= plen) begin
            hit = 1'b1;
            for (int k = 0; k < plen; k++)
              if (recent_bytes[k] !== pattern_bytes[plen-1-k]) hit = 1'b0;
            if (hit) found = 1'b1;
          end
        end
      end
      due_count = verdicts_due.size();
    end
  end

endmodule

// File: verif/tb_line_substring_filter_top.sv
// tb_line_substring_filter_top: drives text, pattern loads and length writes into the
// line substring filter and gives the verdict. Depends on lsf_pkg, the block's RTL and
// line_verdict_checker.
`timescale 1ns / 1ps

module tb_line_substring_filter_top;

  localparam int unsigned PATTERN_MAX = 127;
  localparam int unsigned LINE_MAX    = 255;

  localparam int ITEM_TARGET   = 1200;
  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 64;    // covers the request queue
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up

  // How a line is closed.
  localparam int END_NONE = 0;
  localparam int END_NL   = 1;
  localparam int END_NUL  = 2;
  localparam int END_ANY  = 3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] data_byte, [14:8] pattern_index, [15] zero
  logic [0:0]  s_axis_tuser = '0;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [0] line_matched, [8:1] line_length, [15:9] zero
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;     // pattern_length

  int         fail_count;
  int         due_count;
  int         items_sent = 0;
  int         cur_len = 0;          // pattern length currently programmed
  int         stall_cycles = 0;
  bit         steady = 1'b0;        // both sides run without idling
  bit         sink_hold_req = 1'b0; // ask the receiver for one long hold-off
  logic [7:0] pat_shadow [PATTERN_MAX];

  always #10 clk_i = ~clk_i;

  line_substring_filter_top #(
    .PATTERN_MAX(PATTERN_MAX),
    .LINE_MAX   (LINE_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  line_verdict_checker #(
    .PATTERN_MAX(PATTERN_MAX),
    .LINE_MAX   (LINE_MAX)
  ) u_verdicts (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  // Result receiver: random stalls, none in steady stretches, and one long hold-off
  // on request so the block backs up into its input.
  initial begin : result_sink
    int hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
        if (hold_left == 0) sink_hold_req = 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: restart the count on any handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it. Enter and leave at a
  // falling edge; tvalid stays high on exit, so the caller must drive it next.
  task automatic push_req(input logic cmd, input logic [7:0] value, input logic [6:0] idx);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, idx, value};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every outstanding verdict, then let the queue settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (due_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_length(input int len);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 7'(len);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_len = len;
  endtask

  // Mostly a small alphabet so that matches are common.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(9) < 8) begin
      b = 8'h61 + 8'($urandom_range(2));
    end else begin
      b = 8'($urandom_range(255, 1));
      if (b == lsf_pkg::CHAR_NL) b = 8'h0b;
    end
    return b;
  endfunction

  function automatic logic [7:0] pattern_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'h61 + 8'($urandom_range(2));
  endfunction

  task automatic load_pattern(input int len);
    for (int k = 0; k < len; k++) begin
      pat_shadow[k] = pattern_byte();
      push_req(lsf_pkg::CMD_LOAD, pat_shadow[k], 7'(k));
    end
  endtask

  // One line of text, optionally with the pattern copied in, and now and then a
  // pattern load in the middle of the line.
  task automatic send_line(input int len, input bit embed, input int ending);
    int         start;
    logic [6:0] idx;
    logic [7:0] value;
    start = -1;
    if (embed && len >= cur_len) start = $urandom_range(len - cur_len);
    for (int k = 0; k < len; k++) begin
      value = text_byte();
      if (start >= 0 && k >= start && k < start + cur_len &&
          pat_shadow[k-start] != lsf_pkg::CHAR_NL && pat_shadow[k-start] != lsf_pkg::CHAR_NUL)
        value = pat_shadow[k-start];
      push_req(lsf_pkg::CMD_TEXT, value, 7'($urandom));
      if ($urandom_range(49) == 0) begin
        idx   = 7'($urandom_range(PATTERN_MAX));
        value = pattern_byte();
        if (idx < PATTERN_MAX) pat_shadow[idx] = value;
        push_req(lsf_pkg::CMD_LOAD, value, idx);
      end
    end
    case (ending)
      END_NL:  push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NL, 7'($urandom));
      END_NUL: push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NUL, 7'($urandom));
      END_ANY: push_req(lsf_pkg::CMD_TEXT,
                        $urandom_range(1) ? lsf_pkg::CHAR_NL : lsf_pkg::CHAR_NUL,
                        7'($urandom));
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int phase;
    int len;
    int lines;
    int line_len;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty pattern after reset: an empty line misses, a one-byte line hits.
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NL, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'hff, 7'h7f);
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NUL, 7'h00);

    // Pattern "ab"; the load to the top index must be dropped.
    pat_shadow[0] = 8'h61;
    pat_shadow[1] = 8'h62;
    push_req(lsf_pkg::CMD_LOAD, 8'h61, 7'd0);
    push_req(lsf_pkg::CMD_LOAD, 8'h62, 7'd1);
    push_req(lsf_pkg::CMD_LOAD, 8'hff, 7'h7f);
    write_length(2);
    send_line(0, 1'b0, END_NONE);
    push_req(lsf_pkg::CMD_TEXT, 8'h78, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'h61, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'h62, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'h79, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NL, 7'h00);
    // Reversed order misses.
    push_req(lsf_pkg::CMD_TEXT, 8'h62, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'h61, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NUL, 7'h00);
    // Line shorter than the pattern.
    push_req(lsf_pkg::CMD_TEXT, 8'h61, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NL, 7'h00);
    // Hit, then change the pattern mid-line: the hit must stick.
    push_req(lsf_pkg::CMD_TEXT, 8'h61, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'h62, 7'h00);
    pat_shadow[0] = 8'h7a;
    push_req(lsf_pkg::CMD_LOAD, 8'h7a, 7'd0);
    push_req(lsf_pkg::CMD_TEXT, 8'h71, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NL, 7'h00);
    // New pattern "zb" hits; then a zero byte in the pattern never hits.
    push_req(lsf_pkg::CMD_TEXT, 8'h7a, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'h62, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NL, 7'h00);
    pat_shadow[1] = lsf_pkg::CHAR_NUL;
    push_req(lsf_pkg::CMD_LOAD, lsf_pkg::CHAR_NUL, 7'd1);
    push_req(lsf_pkg::CMD_TEXT, 8'h7a, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, 8'h01, 7'h00);
    push_req(lsf_pkg::CMD_TEXT, lsf_pkg::CHAR_NL, 7'h00);

    // Random phases: new pattern and length, then a batch of lines.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       len = 1;
        1:       len = 0;
        2:       len = PATTERN_MAX;
        default: len = ($urandom_range(7) == 0) ? $urandom_range(PATTERN_MAX)
                                                 : $urandom_range(6);
      endcase
      steady = (phase >= 5 && phase < 8);
      load_pattern(len);
      if ($urandom_range(3) == 0) push_req(lsf_pkg::CMD_LOAD, 8'($urandom), 7'(PATTERN_MAX));
      write_length(len);

      if (phase == 3) begin
        // Starve the result side while short lines keep coming.
        sink_hold_req = 1'b1;
        repeat (80) send_line($urandom_range(3), 1'b0, END_ANY);
      end else begin
        lines = (len > 40) ? 2 : $urandom_range(10, 3);
        for (int n = 0; n < lines; n++) begin
          if ($urandom_range(24) == 0)
            line_len = $urandom_range(300, 250);
          else if (len > 20)
            line_len = $urandom_range(len + 40, len - 5);
          else
            line_len = $urandom_range(len + 12);
          // Leave the last line open now and then, so the next length write
          // lands in mid-line.
          send_line(line_len, $urandom_range(1),
                    (n == lines - 1 && $urandom_range(4) == 0) ? END_NONE : END_ANY);
        end
      end
      phase++;
    end

    steady = 1'b0;
    drain_results();
    if (fail_count == 0 && due_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
